FILE: src/taint_tag_probe_table_defines.svh
// ----------------------------------------------------------------------------
// Taint tag probe table: assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef TAINT_TAG_PROBE_TABLE_DEFINES_SVH
`define TAINT_TAG_PROBE_TABLE_DEFINES_SVH

// same-cycle implication
`define TTPT_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTPT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/ttpt_pkg.sv
// ----------------------------------------------------------------------------
// Taint tag probe table: package
// Operation, status and job types, hash constants and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package ttpt_pkg;

   localparam int MAX_IDX_W   = 16;
   localparam int KEY_W       = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] HASH_MULT_LO = 32'hed558ccd;
   localparam logic [31:0] HASH_MULT_HI = 32'hff51afd7;
   localparam int          HASH_SHIFT   = 33;

   typedef logic [KEY_W-1:0]     key_type;
   typedef logic [MAX_IDX_W-1:0] home_type;

   typedef logic [1:0] op_type;
   localparam op_type OP_TAG   = 2'd0;
   localparam op_type OP_QUERY = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;
   localparam op_type OP_PROP  = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type ST_DONE  = 2'd0;
   localparam status_type ST_NULL  = 2'd1;
   localparam status_type ST_NOENT = 2'd2;
   localparam status_type ST_SKIP  = 2'd3;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_PROBE = 2'd0;
   localparam kind_type KIND_NULL  = 2'd1;
   localparam kind_type KIND_SKIP  = 2'd2;

   typedef logic [1:0] sel_type;
   localparam sel_type SEL_TGT   = 2'd0;
   localparam sel_type SEL_SRC_A = 2'd1;
   localparam sel_type SEL_SRC_B = 2'd2;

   typedef struct packed {
      op_type   op;
      kind_type kind;
      key_type  target_addr;
      key_type  source_a_addr;
      key_type  source_b_addr;
      home_type home_t;
      home_type home_a;
      home_type home_b;
   } job_type;

endpackage

`default_nettype wire

FILE: src/ttpt_if.sv
// ----------------------------------------------------------------------------
// Taint tag probe table: channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttpt_req_if;
   logic               valid;
   logic               ready;
   ttpt_pkg::op_type   operation;
   ttpt_pkg::key_type  target_addr;
   ttpt_pkg::key_type  source_a_addr;
   ttpt_pkg::key_type  source_b_addr;
   logic               owner_present;

   modport source (output valid, operation, target_addr, source_a_addr, source_b_addr,
                   owner_present, input ready);
   modport sink   (input valid, operation, target_addr, source_a_addr, source_b_addr,
                   owner_present, output ready);
endinterface

interface ttpt_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  tagged_res;
   ttpt_pkg::status_type  status;

   modport source (output valid, tagged_res, status, input ready);
   modport sink   (input valid, tagged_res, status, output ready);
endinterface

`default_nettype wire

FILE: src/ttpt_front.sv
// ----------------------------------------------------------------------------
// Taint tag probe table: front end
// Accepts request beats, classifies them and hashes the keys to home slots
// with one shared 32x32 multiplier, then hands a job to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpt_front #(
   parameter int TABLE_SLOTS = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              init_busy,
   ttpt_req_if.sink               req_if,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output ttpt_pkg::job_type      push_job
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_HASH = 2'd1;
   localparam logic [1:0] F_PUSH = 2'd2;

   logic [1:0]         state_ff, state_in;
   ttpt_pkg::job_type  job_ff, job_in;
   ttpt_pkg::sel_type  idx_ff, idx_in;
   logic [1:0]         phase_ff, phase_in;
   logic [63:0]        mul_ff, mul_in;
   logic [63:0]        acc_ff, acc_in;

   logic               req_ready;
   ttpt_pkg::key_type  key_cur;
   logic [63:0]        premix;
   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_out;
   logic [31:0]        prod_hi;
   logic [63:0]        product;
   logic [63:0]        mixed;
   ttpt_pkg::home_type home_new;

   assign req_ready    = (state_ff == F_IDLE) && !init_busy;
   assign req_if.ready = req_ready;
   assign push_valid   = (state_ff == F_PUSH);
   assign push_job     = job_ff;

   always_comb begin
      case (idx_ff)
         ttpt_pkg::SEL_TGT:   key_cur = job_ff.target_addr;
         ttpt_pkg::SEL_SRC_A: key_cur = job_ff.source_a_addr;
         default:             key_cur = job_ff.source_b_addr;
      endcase
      premix = key_cur ^ (key_cur >> ttpt_pkg::HASH_SHIFT);
      case (phase_ff)
         2'd1: begin
            mul_a = premix[63:32];
            mul_b = ttpt_pkg::HASH_MULT_LO;
         end
         2'd2: begin
            mul_a = premix[31:0];
            mul_b = ttpt_pkg::HASH_MULT_HI;
         end
         default: begin
            mul_a = premix[31:0];
            mul_b = ttpt_pkg::HASH_MULT_LO;
         end
      endcase
   end

   assign mul_out  = mul_a * mul_b;
   assign prod_hi  = acc_ff[63:32] + mul_ff[31:0];
   assign product  = {prod_hi, acc_ff[31:0]};
   assign mixed    = product ^ (product >> ttpt_pkg::HASH_SHIFT);
   assign home_new = ttpt_pkg::home_type'(mixed[IDX_W-1:0]);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;
      mul_in   = mul_ff;
      acc_in   = acc_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_if.valid && req_ready) begin
               job_in.op            = req_if.operation;
               job_in.target_addr   = req_if.target_addr;
               job_in.source_a_addr = req_if.source_a_addr;
               job_in.source_b_addr = req_if.source_b_addr;
               job_in.home_t        = '0;
               job_in.home_a        = '0;
               job_in.home_b        = '0;
               idx_in               = ttpt_pkg::SEL_TGT;
               phase_in             = 2'd0;
               if (req_if.target_addr == '0) begin
                  job_in.kind = ttpt_pkg::KIND_NULL;
                  state_in    = F_PUSH;
               end else if (req_if.operation == ttpt_pkg::OP_TAG && !req_if.owner_present) begin
                  job_in.kind = ttpt_pkg::KIND_SKIP;
                  state_in    = F_PUSH;
               end else begin
                  job_in.kind = ttpt_pkg::KIND_PROBE;
                  state_in    = F_HASH;
               end
            end
         end
         F_HASH: begin
            mul_in   = mul_out;
            phase_in = phase_ff + 2'd1;
            case (phase_ff)
               2'd1: acc_in = mul_ff;
               2'd2: acc_in = product;
               2'd3: begin
                  case (idx_ff)
                     ttpt_pkg::SEL_TGT:   job_in.home_t = home_new;
                     ttpt_pkg::SEL_SRC_A: job_in.home_a = home_new;
                     default:             job_in.home_b = home_new;
                  endcase
                  if (job_ff.op == ttpt_pkg::OP_PROP && idx_ff != ttpt_pkg::SEL_SRC_B) begin
                     idx_in = idx_ff + 2'd1;
                  end else begin
                     state_in = F_PUSH;
                  end
               end
               default: acc_in = acc_ff;
            endcase
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      idx_ff   <= idx_in;
      phase_ff <= phase_in;
      mul_ff   <= mul_in;
      acc_ff   <= acc_in;
   end

endmodule

`default_nettype wire

FILE: src/ttpt_queue.sv
// ----------------------------------------------------------------------------
// Taint tag probe table: job queue
// Short FIFO between the front end and the probe engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ttpt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire ttpt_pkg::job_type push_job,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output ttpt_pkg::job_type      pop_job
);

   ttpt_pkg::job_type              entry_ff [ttpt_pkg::QUEUE_DEPTH];
   logic [ttpt_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ttpt_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ttpt_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                           push_fire, pop_fire;

   assign push_ready = (count_ff != ttpt_pkg::QCNT_W'(ttpt_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == ttpt_pkg::QPTR_W'(ttpt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == ttpt_pkg::QPTR_W'(ttpt_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                                : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: src/ttpt_back.sv
// ----------------------------------------------------------------------------
// Taint tag probe table: probe engine
// Owns the slot memory, clears it after reset, walks probe runs one slot per
// cycle, applies tag updates and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "taint_tag_probe_table_defines.svh"

module ttpt_back #(
   parameter int TABLE_SLOTS = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   output logic                   init_busy,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   input  wire ttpt_pkg::job_type pop_job,
   ttpt_rsp_if.source             rsp_if
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   localparam logic [1:0] B_CLEAR  = 2'd0;
   localparam logic [1:0] B_IDLE   = 2'd1;
   localparam logic [1:0] B_LOOK   = 2'd2;
   localparam logic [1:0] B_FINISH = 2'd3;

   logic [ttpt_pkg::KEY_W:0] mem [TABLE_SLOTS];
   logic [ttpt_pkg::KEY_W:0] rd_data_ff;

   logic [1:0]           state_ff, state_in;
   logic [IDX_W-1:0]     clr_addr_ff, clr_addr_in;
   ttpt_pkg::job_type    job_ff, job_in;
   ttpt_pkg::sel_type    sel_ff, sel_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]     tgt_pos_ff, tgt_pos_in;
   logic                 tgt_ok_ff, tgt_ok_in;
   logic                 res_tag_ff, res_tag_in;
   ttpt_pkg::status_type res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_tag_ff, rsp_tag_in;
   ttpt_pkg::status_type rsp_status_ff, rsp_status_in;

   logic [IDX_W-1:0]         rd_addr;
   logic                     mem_we;
   logic [IDX_W-1:0]         wr_addr;
   logic [ttpt_pkg::KEY_W:0] wr_data;

   ttpt_pkg::key_type key_cur;
   logic [IDX_W-1:0]  home_cur;
   ttpt_pkg::key_type slot_key;
   logic              slot_tag;
   logic              hit, empty, last;
   logic              want_a, want_b;

   assign init_busy      = (state_ff == B_CLEAR);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.tagged_res = rsp_tag_ff;
   assign rsp_if.status     = rsp_status_ff;

   always_comb begin
      case (sel_ff)
         ttpt_pkg::SEL_TGT: begin
            key_cur  = job_ff.target_addr;
            home_cur = job_ff.home_t[IDX_W-1:0];
         end
         ttpt_pkg::SEL_SRC_A: begin
            key_cur  = job_ff.source_a_addr;
            home_cur = job_ff.home_a[IDX_W-1:0];
         end
         default: begin
            key_cur  = job_ff.source_b_addr;
            home_cur = job_ff.home_b[IDX_W-1:0];
         end
      endcase
   end

   assign slot_key = rd_data_ff[ttpt_pkg::KEY_W-1:0];
   assign slot_tag = rd_data_ff[ttpt_pkg::KEY_W];
   assign hit      = (slot_key == key_cur);
   assign empty    = (slot_key == '0);
   assign last     = (cnt_ff == IDX_W'(TABLE_SLOTS - 1));
   assign want_a   = (job_ff.source_a_addr != '0);
   assign want_b   = (job_ff.source_b_addr != '0);

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      job_in        = job_ff;
      sel_in        = sel_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      tgt_pos_in    = tgt_pos_ff;
      tgt_ok_in     = tgt_ok_ff;
      res_tag_in    = res_tag_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = pos_ff;
      mem_we        = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = '0;
      pop_ready     = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            mem_we      = 1'b1;
            wr_addr     = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               job_in = pop_job;
               case (pop_job.kind)
                  ttpt_pkg::KIND_PROBE: begin
                     rd_addr  = pop_job.home_t[IDX_W-1:0];
                     pos_in   = pop_job.home_t[IDX_W-1:0];
                     cnt_in   = '0;
                     sel_in   = ttpt_pkg::SEL_TGT;
                     state_in = B_LOOK;
                  end
                  ttpt_pkg::KIND_SKIP: begin
                     res_tag_in    = 1'b0;
                     res_status_in = ttpt_pkg::ST_SKIP;
                     state_in      = B_FINISH;
                  end
                  default: begin
                     res_tag_in    = 1'b0;
                     res_status_in = ttpt_pkg::ST_NULL;
                     state_in      = B_FINISH;
                  end
               endcase
            end
         end
         B_LOOK: begin
            if (!hit && !empty && !last) begin
               rd_addr = pos_ff + 1'b1;
               pos_in  = pos_ff + 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               state_in      = B_FINISH;
               res_tag_in    = 1'b0;
               res_status_in = ttpt_pkg::ST_NOENT;
               case (sel_ff)
                  ttpt_pkg::SEL_TGT: begin
                     case (job_ff.op)
                        ttpt_pkg::OP_TAG: begin
                           if (hit || empty) begin
                              mem_we        = 1'b1;
                              wr_data       = {1'b1, key_cur};
                              res_tag_in    = 1'b1;
                              res_status_in = ttpt_pkg::ST_DONE;
                           end
                        end
                        ttpt_pkg::OP_QUERY: begin
                           if (hit) begin
                              res_tag_in    = slot_tag;
                              res_status_in = ttpt_pkg::ST_DONE;
                           end
                        end
                        ttpt_pkg::OP_CLEAR: begin
                           if (hit) begin
                              mem_we        = 1'b1;
                              wr_data       = {1'b0, key_cur};
                              res_status_in = ttpt_pkg::ST_DONE;
                           end
                        end
                        default: begin
                           tgt_pos_in = pos_ff;
                           tgt_ok_in  = hit || empty;
                           if (hit && slot_tag) begin
                              res_tag_in    = 1'b1;
                              res_status_in = ttpt_pkg::ST_SKIP;
                           end else if (want_a) begin
                              rd_addr  = job_ff.home_a[IDX_W-1:0];
                              pos_in   = job_ff.home_a[IDX_W-1:0];
                              cnt_in   = '0;
                              sel_in   = ttpt_pkg::SEL_SRC_A;
                              state_in = B_LOOK;
                           end else if (want_b) begin
                              rd_addr  = job_ff.home_b[IDX_W-1:0];
                              pos_in   = job_ff.home_b[IDX_W-1:0];
                              cnt_in   = '0;
                              sel_in   = ttpt_pkg::SEL_SRC_B;
                              state_in = B_LOOK;
                           end else begin
                              res_status_in = ttpt_pkg::ST_SKIP;
                           end
                        end
                     endcase
                  end
                  default: begin
                     if (hit && slot_tag) begin
                        if (tgt_ok_ff) begin
                           mem_we        = 1'b1;
                           wr_addr       = tgt_pos_ff;
                           wr_data       = {1'b1, job_ff.target_addr};
                           res_tag_in    = 1'b1;
                           res_status_in = ttpt_pkg::ST_DONE;
                        end
                     end else if (sel_ff == ttpt_pkg::SEL_SRC_A && want_b) begin
                        rd_addr  = job_ff.home_b[IDX_W-1:0];
                        pos_in   = job_ff.home_b[IDX_W-1:0];
                        cnt_in   = '0;
                        sel_in   = ttpt_pkg::SEL_SRC_B;
                        state_in = B_LOOK;
                     end else begin
                        res_status_in = ttpt_pkg::ST_SKIP;
                     end
                  end
               endcase
            end
         end
         B_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_tag_in    = res_tag_ff;
               rsp_status_in = res_status_ff;
               state_in      = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      sel_ff        <= sel_in;
      pos_ff        <= pos_in;
      cnt_ff        <= cnt_in;
      tgt_pos_ff    <= tgt_pos_in;
      tgt_ok_ff     <= tgt_ok_in;
      res_tag_ff    <= res_tag_in;
      res_status_ff <= res_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   `TTPT_ASSERT_IMPL(a_clear_sweep_full, clock, reset, (state_ff == B_IDLE && $past(state_ff) == B_CLEAR), ($past(clr_addr_ff) == {IDX_W{1'b1}}), "clear sweep ended early")
   `TTPT_ASSERT_IMPL(a_probe_pos, clock, reset, (state_ff == B_LOOK), (pos_ff == IDX_W'(home_cur + cnt_ff)), "probe position off its run")
   `TTPT_ASSERT_IMPL(a_no_null_store, clock, reset, (mem_we && state_ff != B_CLEAR), (wr_data[ttpt_pkg::KEY_W-1:0] != '0), "null key written to a slot")
   `TTPT_ASSERT_NEXT(a_write_then_finish, clock, reset, (mem_we && state_ff == B_LOOK), (state_ff == B_FINISH), "slot update not followed by finish")

endmodule

`default_nettype wire

FILE: src/taint_tag_probe_table.sv
// ----------------------------------------------------------------------------
// Taint tag probe table: top level
// Open-addressed taint tag table keyed by 64-bit addresses, mixing hash and
// linear probing. A front end hashes keys, a probe engine walks the table.
//
//   channel  dir  handshake          payload
//   req_if   in   valid/ready        operation, target/source addresses, owner
//   rsp_if   out  valid/ready        tagged_res, status
//
// Front end: an accept state, then a hash pass per key on the shared
//   32x32 multiplier (one key, three for propagate), then a push to the queue.
// Probe engine: issues each lookup, then reads the single-read slot memory slot
//   by slot along its probe run (up to three lookups), then loads the result.
// Reset: a clearing sweep over all TABLE_SLOTS slots; req_if.ready stays low.
// Stalls: a two-job queue and the response register decouple both sides.
// TABLE_SLOTS must be a power of two; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module taint_tag_probe_table #(
   parameter int TABLE_SLOTS = 4096
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ttpt_req_if.sink   req_if,
   ttpt_rsp_if.source rsp_if
);

   logic              init_busy;
   logic              push_valid, push_ready;
   ttpt_pkg::job_type push_job;
   logic              pop_valid, pop_ready;
   ttpt_pkg::job_type pop_job;

   ttpt_front #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .init_busy  (init_busy),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   ttpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   ttpt_back #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .init_busy (init_busy),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_job   (pop_job),
      .rsp_if    (rsp_if)
   );

endmodule

`default_nettype wire
